[hw/rtl/grg_pkg.sv]
// Shared types, widths and constants for the gamma ramp generator.
// No dependencies; used by every module of the block.
package grg_pkg;

    localparam int FRAC_W  = 30;               // fraction bits of log2 and exp2 values
    localparam int IDX_W   = 12;               // entry_index width
    localparam int LEN_W   = 13;               // ramp_length width
    localparam int G_W     = 16;               // gamma_q4_12 width
    localparam int LVL_W   = 16;               // level width
    localparam int EXP_W   = 4;                // integer part of a log2 value
    localparam int LOG_W   = EXP_W + FRAC_W;   // Q4.30 log2 value
    localparam int NUM_W   = LOG_W + 13;       // (lmag << 12) + gamma/2
    localparam int Q_INT_W = 5;                // integer part of the exponent
    localparam int QUO_W   = Q_INT_W + FRAC_W; // exponent magnitude
    localparam int Q_LIMIT = 17;               // exponents at or above give zero

    localparam int LOG_LAT = FRAC_W + 1;       // normalize plus one bit a stage
    localparam int DIV_LAT = QUO_W;            // one quotient bit a stage
    localparam int EXP_LAT = FRAC_W;           // one factor a stage

    localparam logic [G_W-1:0]   G_ONE   = 16'd4096;
    localparam logic [LVL_W-1:0] LVL_MAX = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_GAMMA  = 1'b0,
        REG_LENGTH = 1'b1
    } cfg_reg_t;

    // Control that travels beside the arithmetic
    typedef struct packed {
        logic             valid;
        logic             special;
        logic             oor;
        logic [LVL_W-1:0] level;
    } grg_side_t;

    // Floor square root, evaluated at elaboration only
    function automatic logic [63:0] grg_isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Factor 2^(-2^-k) in Q.30 as repeated floor square roots of one half
    function automatic logic [FRAC_W:0] grg_fac(input int k);
        logic [63:0] f;
        f = 64'd1 << (FRAC_W - 1);
        for (int i = 0; i < k; i++) f = grg_isqrt(f << FRAC_W);
        return f[FRAC_W:0];
    endfunction

endpackage

[hw/rtl/grg_log2.sv]
// Pipelined log2 of a 13-bit integer, Q4.30 result, one fraction bit a stage.
// Depends on grg_pkg.
module grg_log2
    import grg_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [LEN_W-1:0] n,
    output logic [LOG_W-1:0] log_out
);

    logic [FRAC_W:0]   m_reg    [LOG_LAT];
    logic [EXP_W-1:0]  e_reg    [LOG_LAT];
    logic [FRAC_W-1:0] frac_reg [LOG_LAT];

    logic [EXP_W-1:0]  e_next;
    logic [FRAC_W:0]   m_next;

    // Find the leading one and normalize into [1,2)
    always_comb begin
        e_next = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (n[i]) e_next = EXP_W'(i);
        end
        m_next = (FRAC_W + 1)'({{(FRAC_W + 1 - LEN_W){1'b0}}, n} << (FRAC_W - int'(e_next)));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= m_next;
            e_reg[0]    <= e_next;
            frac_reg[0] <= '0;
        end
    end

    // Square and compare: one fraction bit per stage, most significant first
    for (genvar j = 1; j < LOG_LAT; j++) begin : g_step
        logic [2*FRAC_W+1:0] prod;
        logic [FRAC_W+1:0]   sq;
        assign prod = m_reg[j-1] * m_reg[j-1];
        assign sq   = prod[2*FRAC_W+1:FRAC_W];

        always_ff @(posedge aclk) begin
            if (en) begin
                e_reg[j] <= e_reg[j-1];
                if (sq[FRAC_W+1]) begin
                    m_reg[j]    <= sq[FRAC_W+1:1];
                    frac_reg[j] <= frac_reg[j-1] | (FRAC_W'(1) << (FRAC_W - j));
                end else begin
                    m_reg[j]    <= sq[FRAC_W:0];
                    frac_reg[j] <= frac_reg[j-1];
                end
            end
        end
    end

    assign log_out = {e_reg[LOG_LAT-1], frac_reg[LOG_LAT-1]};

endmodule

[hw/rtl/grg_div.sv]
// Pipelined restoring divider: 35-bit quotient, one bit a stage.
// Depends on grg_pkg. Numerator must be below den << QUO_W.
module grg_div
    import grg_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [G_W-1:0]   den,
    output logic [QUO_W-1:0] quo
);

    logic [G_W-1:0]   rem_reg  [DIV_LAT];
    logic [QUO_W-1:0] numl_reg [DIV_LAT];
    logic [QUO_W-1:0] quo_reg  [DIV_LAT];

    for (genvar i = 0; i < DIV_LAT; i++) begin : g_step
        logic [G_W-1:0]   rem_in;
        logic [QUO_W-1:0] numl_in;
        logic [QUO_W-1:0] quo_in;
        logic [G_W:0]     trial;

        if (i == 0) begin : g_first
            assign rem_in  = G_W'(num[NUM_W-1:QUO_W]);
            assign numl_in = num[QUO_W-1:0];
            assign quo_in  = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign numl_in = numl_reg[i-1];
            assign quo_in  = quo_reg[i-1];
        end

        assign trial = {rem_in, numl_in[QUO_W-1-i]};

        // Subtract when the divisor fits, shift in the quotient bit
        always_ff @(posedge aclk) begin
            if (en) begin
                numl_reg[i] <= numl_in;
                if (trial >= {1'b0, den}) begin
                    rem_reg[i] <= G_W'(trial - {1'b0, den});
                    quo_reg[i] <= {quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[G_W-1:0];
                    quo_reg[i] <= {quo_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

[hw/rtl/gamma_ramp_generator.sv]
// Gamma ramp generator: level = round(65535 * (index/length)^(1/gamma)),
// or {index[7:0], 8'd0} | index at gamma 1.0. Stages: log2, scale, divide,
// exp2, multiply, round. Throughput: one item per cycle when not held.
// The whole pipeline holds while the output register is full and not taken.
// Reset (aresetn, synchronous, active low) clears all valid bits and loads
// gamma 1.0 and ramp length 256.
module gamma_ramp_generator
    import grg_pkg::*;
#(
    parameter int MAX_RAMP = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_index,
    input  logic [G_W-1:0]   cfg_data,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [IDX_W-1:0] s_entry_index,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [LVL_W-1:0] m_level,
    output logic             m_out_of_range
);

    localparam int SB_N    = LOG_LAT + 1 + DIV_LAT + EXP_LAT + 1;
    localparam int LEN_TOP = (1 << LEN_W) - 1;
    localparam int LEN_SAT = (MAX_RAMP < LEN_TOP) ? MAX_RAMP : LEN_TOP;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_SAT);

    logic [G_W-1:0]   gamma_reg;
    logic [LEN_W-1:0] length_reg;
    logic             pipe_en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg  <= G_ONE;
            length_reg <= LEN_W'(256);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAMMA:  gamma_reg  <= cfg_data;
                REG_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic             m_valid_reg;
    logic [LVL_W-1:0] m_level_reg;
    logic             m_oor_reg;

    // Advance everything unless the output register is held
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // Entry decode: range check and the cases that skip the power
    logic [LEN_W-1:0] len_sat;
    grg_side_t        sb_in;

    always_comb begin
        len_sat        = (length_reg > LEN_CAP) ? LEN_CAP : length_reg;
        sb_in.valid    = s_valid;
        sb_in.oor      = ({1'b0, s_entry_index} >= len_sat);
        sb_in.special  = 1'b1;
        sb_in.level    = '0;
        if (sb_in.oor) begin
            sb_in.level = LVL_MAX;
        end else if (gamma_reg == '0) begin
            sb_in.level = '0;
        end else if (gamma_reg == G_ONE) begin
            sb_in.level = {s_entry_index[7:0], 8'd0} | LVL_W'(s_entry_index);
        end else if (s_entry_index == '0) begin
            sb_in.level = '0;
        end else begin
            sb_in.special = 1'b0;
        end
    end

    // Log2 of index and length in parallel lanes
    logic [LOG_W-1:0] log_idx;
    logic [LOG_W-1:0] log_len;

    grg_log2 u_log_idx (
        .aclk    (aclk),
        .en      (pipe_en),
        .n       ({1'b0, s_entry_index}),
        .log_out (log_idx)
    );

    grg_log2 u_log_len (
        .aclk    (aclk),
        .en      (pipe_en),
        .n       (len_sat),
        .log_out (log_len)
    );

    // Scale stage: numerator for the divide and the exponent overflow test
    logic [LOG_W-1:0]  lmag;
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  num_reg;
    logic [G_W+4:0]    g17;
    logic              ovf;

    always_comb begin
        lmag     = log_len - log_idx;
        num_next = {1'b0, lmag, 12'd0} + NUM_W'(gamma_reg[G_W-1:1]);
        g17      = (G_W + 5)'(gamma_reg) * (G_W + 5)'(Q_LIMIT);
        ovf      = ({4'd0, num_next} >= {g17, {FRAC_W{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) num_reg <= num_next;
    end

    // Sideband line, with overflow folded in at the scale stage
    grg_side_t sb_reg [SB_N];
    grg_side_t sb_a;

    always_comb begin
        sb_a = sb_reg[LOG_LAT-1];
        if (ovf && !sb_a.special) begin
            sb_a.special = 1'b1;
            sb_a.level   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SB_N; j++) sb_reg[j].valid <= 1'b0;
        end else if (pipe_en) begin
            sb_reg[0] <= sb_in;
            for (int j = 1; j < SB_N; j++) begin
                sb_reg[j] <= (j == LOG_LAT) ? sb_a : sb_reg[j-1];
            end
        end
    end

    // Exponent magnitude
    logic [QUO_W-1:0] ymag;

    grg_div u_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (num_reg),
        .den  (gamma_reg),
        .quo  (ymag)
    );

    // exp2 of the negated fraction: one conditional factor per stage
    logic [FRAC_W:0]  acc_reg  [EXP_LAT];
    logic [QUO_W-1:0] ymag_reg [EXP_LAT];

    for (genvar j = 0; j < EXP_LAT; j++) begin : g_exp
        localparam logic [FRAC_W:0] FAC = grg_fac(j + 1);
        logic [FRAC_W:0]     acc_in;
        logic [QUO_W-1:0]    y_in;
        logic [2*FRAC_W+1:0] prod;

        if (j == 0) begin : g_first
            assign acc_in = (FRAC_W + 1)'(1) << FRAC_W;
            assign y_in   = ymag;
        end else begin : g_rest
            assign acc_in = acc_reg[j-1];
            assign y_in   = ymag_reg[j-1];
        end

        assign prod = acc_in * FAC + ((2 * FRAC_W + 2)'(1) << (FRAC_W - 1));

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                ymag_reg[j] <= y_in;
                acc_reg[j]  <= y_in[FRAC_W-1-j] ? prod[2*FRAC_W:FRAC_W] : acc_in;
            end
        end
    end

    // Scale by full range
    logic [NUM_W-1:0]   total_reg;
    logic [Q_INT_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            total_reg <= NUM_W'(acc_reg[EXP_LAT-1]) * NUM_W'(LVL_MAX);
            q_reg     <= ymag_reg[EXP_LAT-1][QUO_W-1:FRAC_W];
        end
    end

    // Round by the integer exponent and clamp
    logic [NUM_W:0]   rsum;
    logic [NUM_W:0]   rshift;
    logic [LVL_W-1:0] pow_level;

    always_comb begin
        rsum      = {1'b0, total_reg} + ((NUM_W + 1)'(1) << (6'(q_reg) + 6'(FRAC_W - 1)));
        rshift    = rsum >> (6'(q_reg) + 6'(FRAC_W));
        pow_level = (rshift > (NUM_W + 1)'(LVL_MAX)) ? LVL_MAX : rshift[LVL_W-1:0];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= sb_reg[SB_N-1].valid;
            m_oor_reg   <= sb_reg[SB_N-1].oor;
            m_level_reg <= sb_reg[SB_N-1].special ? sb_reg[SB_N-1].level : pow_level;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_level        = m_level_reg;
    assign m_out_of_range = m_oor_reg;

    logic [SB_N-1:0] sb_valid;
    always_comb begin
        for (int j = 0; j < SB_N; j++) sb_valid[j] = sb_reg[j].valid;
    end

`ifndef NO_ASSERTIONS
    a_oor_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_level == LVL_MAX)
        else $error("out-of-range item without full-scale level");

    a_zero_gamma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range && gamma_reg == '0 |-> m_level == '0)
        else $error("zero gamma gave nonzero level");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(sb_valid))
        else $error("pipeline moved during a stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && sb_valid == '0)
        else $error("valid bits survive reset");
`endif

endmodule
